// ----- design/usb_control_request_responder_defines.svh -----
// ----------------------------------------------------------------------------
// USB control request responder: assertion macros
// Shared concurrent assertion macros, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_REQUEST_RESPONDER_DEFINES_SVH
`define USB_CONTROL_REQUEST_RESPONDER_DEFINES_SVH

`ifndef SYNTH
`define UCRR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UCRR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define UCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UCRR_ASSERT(label, clk, rst_n, prop, msg)
`define UCRR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define UCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/ucrr_pkg.sv -----
// ----------------------------------------------------------------------------
// USB control request responder: package
// Request codes, descriptor tables and the types passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ucrr_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] VENDOR_ID_RESET  = 16'd1155;
	localparam logic [15:0] PRODUCT_ID_RESET = 16'd22336;

	localparam logic REG_VENDOR_ID  = 1'b0;
	localparam logic REG_PRODUCT_ID = 1'b1;

	localparam logic KIND_SETUP = 1'b0;
	localparam logic KIND_OUT   = 1'b1;

	localparam logic [7:0] REQ_SET_ADDRESS            = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR         = 8'd6;
	localparam logic [7:0] REQ_SET_CONFIGURATION      = 8'd9;
	localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'd34;

	localparam logic [15:0] DESC_DEVICE = 16'h0100;
	localparam logic [15:0] DESC_CONFIG = 16'h0200;

	localparam logic [6:0] DEV_DESC_LEN = 7'd18;
	localparam logic [6:0] CFG_DESC_LEN = 7'd67;

	localparam logic [7:0] CFG_DESC [0:66] = '{
		8'd9, 8'd2, 8'd67, 8'd0, 8'd2, 8'd1, 8'd0, 8'd192, 8'd50,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'd2, 8'd2, 8'd0, 8'd0,
		8'd5, 8'd36, 8'd0, 8'd16, 8'd1,
		8'd5, 8'd36, 8'd1, 8'd0, 8'd1,
		8'd4, 8'd36, 8'd2, 8'd2,
		8'd5, 8'd36, 8'd6, 8'd0, 8'd1,
		8'd7, 8'd5, 8'd130, 8'd3, 8'd8, 8'd0, 8'd255,
		8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'd10, 8'd0, 8'd0, 8'd0,
		8'd7, 8'd5, 8'd1, 8'd2, 8'd64, 8'd0, 8'd0,
		8'd7, 8'd5, 8'd129, 8'd2, 8'd64, 8'd0, 8'd0
	};

	typedef enum logic [1:0] {
		SEL_NONE   = 2'd0,
		SEL_DEVICE = 2'd1,
		SEL_CONFIG = 2'd2
	} desc_sel_t;

	typedef struct packed {
		logic       armed;
		logic [6:0] dlen;
		desc_sel_t  sel;
		logic [6:0] address;
		logic       configured;
		logic       dtr;
	} cmd_t;

	typedef struct packed {
		logic        armed;
		logic [6:0]  len;
		logic        word_valid;
		logic [31:0] word;
		logic        last;
		logic [6:0]  address;
		logic        configured;
		logic        dtr;
	} result_t;

	function automatic logic [7:0] desc_byte(input desc_sel_t sel, input logic [6:0] pos,
			input logic [15:0] vid, input logic [15:0] pid);
		logic [7:0] b;
		b = '0;
		case (sel)
			SEL_DEVICE: begin
				case (pos)
					7'd0:    b = 8'd18;
					7'd1:    b = 8'd1;
					7'd3:    b = 8'd2;
					7'd4:    b = 8'd2;
					7'd7:    b = 8'd64;
					7'd8:    b = vid[7:0];
					7'd9:    b = vid[15:8];
					7'd10:   b = pid[7:0];
					7'd11:   b = pid[15:8];
					7'd13:   b = 8'd2;
					7'd17:   b = 8'd1;
					default: b = '0;
				endcase
			end
			SEL_CONFIG: begin
				if (pos < CFG_DESC_LEN) begin
					b = CFG_DESC[pos];
				end
			end
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- design/usb_control_request_responder.sv -----
// ----------------------------------------------------------------------------
// USB control request responder
// Endpoint 0 request handling for a CDC-ACM serial device.
// ----------------------------------------------------------------------------
// The s_ channel takes one beat per setup packet or OUT data packet, kind in
// s_tuser. The m_ channel returns the result beats of each item in order: one
// status beat, or one beat per 32-bit descriptor word with m_tlast on the
// final word. The cfg_ channel writes the vendor and product identifiers; it
// is always ready.
// An accepted item enters a command queue in the cycle it arrives, so s_tready
// is low only while the queue is full. The first result beat is registered
// once the item reaches the queue head. The back end then emits one beat per
// cycle while m_tready is high: an item gives one status beat or up to 17
// word beats for the longest reply, a figure set by the 67-byte descriptor.
// When m_tready is low the output beat holds and the back end waits; the front
// end keeps taking items until the queue fills.
// Reset clears the address, configured and DTR flags, the remaining length
// and the queue, and restores the identifiers to their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_request_responder #(
	parameter int QUEUE_DEPTH = ucrr_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,  // request_type_bits, request_code, request_value,
	                              // request_length, out_byte_count, zero fill
	input  wire  [0:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // reply_length, reply_word, device_address,
	                              // configured, line_dtr
	output logic [1:0]  m_tuser,  // reply_armed, word_valid
	output logic        m_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	logic              accept, push, pop, empty, full;
	ucrr_pkg::cmd_t    cmd, head;
	ucrr_pkg::result_t res;
	logic [15:0]       vendor_q, product_q;

	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q  <= ucrr_pkg::VENDOR_ID_RESET;
			product_q <= ucrr_pkg::PRODUCT_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index[0])
				ucrr_pkg::REG_VENDOR_ID:  vendor_q  <= cfg_data;
				ucrr_pkg::REG_PRODUCT_ID: product_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ucrr_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.req_type          (s_tuser[0]),
		.request_type_bits (s_tdata[7:0]),
		.request_code      (s_tdata[15:8]),
		.request_value     (s_tdata[31:16]),
		.request_length    (s_tdata[47:32]),
		.out_byte_count    (s_tdata[58:48]),
		.push              (push),
		.cmd               (cmd)
	);

	ucrr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	ucrr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.vendor_id  (vendor_q),
		.product_id (product_q),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {res.dtr, res.configured, res.address, res.word, res.len};
	assign m_tuser = {res.word_valid, res.armed};
	assign m_tlast = res.last;

endmodule

`default_nettype wire

// ----- design/ucrr_front.sv -----
// ----------------------------------------------------------------------------
// USB control request responder: front end
// Accepts setup and OUT items, updates the device state and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module ucrr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  wire                 req_type,
	input  wire  [7:0]          request_type_bits,
	input  wire  [7:0]          request_code,
	input  wire  [15:0]         request_value,
	input  wire  [15:0]         request_length,
	input  wire  [10:0]         out_byte_count,
	output logic                push,
	output ucrr_pkg::cmd_t      cmd
);

	logic [15:0] rem_q, rem_d;
	logic [6:0]  addr_q, addr_d;
	logic        conf_q, conf_d;
	logic        dtr_q, dtr_d;
	logic [15:0] cnt_ext;
	logic [6:0]  full_len;
	logic        reply;

	always_comb begin
		rem_d    = rem_q;
		addr_d   = addr_q;
		conf_d   = conf_q;
		dtr_d    = dtr_q;
		full_len = '0;
		reply    = 1'b0;
		cnt_ext  = {5'd0, out_byte_count};
		cmd.sel  = ucrr_pkg::SEL_NONE;
		cmd.dlen = '0;
		if (req_type == ucrr_pkg::KIND_OUT) begin
			rem_d     = (cnt_ext >= rem_q) ? 16'd0 : rem_q - cnt_ext;
			cmd.armed = (rem_d == 16'd0);
		end else begin
			rem_d = request_length;
			case (request_code)
				ucrr_pkg::REQ_SET_ADDRESS: begin
					addr_d = request_value[6:0];
				end
				ucrr_pkg::REQ_GET_DESCRIPTOR: begin
					if (request_value == ucrr_pkg::DESC_DEVICE) begin
						cmd.sel  = ucrr_pkg::SEL_DEVICE;
						full_len = ucrr_pkg::DEV_DESC_LEN;
					end else if (request_value == ucrr_pkg::DESC_CONFIG) begin
						cmd.sel  = ucrr_pkg::SEL_CONFIG;
						full_len = ucrr_pkg::CFG_DESC_LEN;
					end
				end
				ucrr_pkg::REQ_SET_CONFIGURATION: begin
					conf_d = 1'b1;
				end
				ucrr_pkg::REQ_SET_CONTROL_LINE_STATE: begin
					dtr_d = request_value[0];
				end
				default: begin
				end
			endcase
			reply     = (request_length == 16'd0) || request_type_bits[7];
			cmd.armed = reply;
			if (reply) begin
				cmd.dlen = (request_length < {9'd0, full_len}) ? request_length[6:0] : full_len;
			end
		end
		cmd.address    = addr_d;
		cmd.configured = conf_d;
		cmd.dtr        = dtr_d;
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			addr_q <= '0;
			conf_q <= 1'b0;
			dtr_q  <= 1'b0;
		end else if (accept) begin
			rem_q  <= rem_d;
			addr_q <= addr_d;
			conf_q <= conf_d;
			dtr_q  <= dtr_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/ucrr_queue.sv -----
// ----------------------------------------------------------------------------
// USB control request responder: command queue
// Short first-in first-out store of commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_control_request_responder_defines.svh"

module ucrr_queue #(
	parameter int DEPTH = ucrr_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  ucrr_pkg::cmd_t      wr_cmd,
	input  wire                 pop,
	output ucrr_pkg::cmd_t      head,
	output logic                empty,
	output logic                full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	ucrr_pkg::cmd_t   store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`UCRR_ASSERT(a_no_overflow, clk, arst_n, !(push && full && !pop), "push into a full queue")
	`UCRR_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "pop from an empty queue")

endmodule

`default_nettype wire

// ----- design/ucrr_back.sv -----
// ----------------------------------------------------------------------------
// USB control request responder: back end
// Turns queued commands into result beats, one descriptor word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usb_control_request_responder_defines.svh"

module ucrr_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ucrr_pkg::cmd_t      head,
	input  wire                 empty,
	output logic                pop,
	input  wire  [15:0]         vendor_id,
	input  wire  [15:0]         product_id,
	output logic                res_valid,
	input  wire                 res_ready,
	output ucrr_pkg::result_t   res
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} bstate_t;

	bstate_t           state_q;
	ucrr_pkg::cmd_t    cur_q, src;
	logic [4:0]        widx_q, widx;
	logic [6:0]        base;
	logic [6:0]        pos [4];
	logic [31:0]       word;
	logic [7:0]        end_pos;
	logic              is_last;
	logic              can_load, load_first, load_next;
	logic              out_valid_q;
	ucrr_pkg::result_t res_q, res_d;

	always_comb begin
		src     = (state_q == B_RUN) ? cur_q : head;
		widx    = (state_q == B_RUN) ? widx_q : 5'd0;
		base    = {widx, 2'b00};
		end_pos = {1'b0, base} + 8'd4;
		is_last = (end_pos >= {1'b0, src.dlen});
		for (int b = 0; b < 4; b++) begin
			pos[b] = base + 7'(b);
			word[8*b +: 8] = (pos[b] < src.dlen) ?
				ucrr_pkg::desc_byte(src.sel, pos[b], vendor_id, product_id) : 8'd0;
		end
		res_d.armed      = src.armed;
		res_d.len        = src.dlen;
		res_d.word_valid = (src.dlen != '0);
		res_d.word       = word;
		res_d.last       = (src.dlen == '0) || is_last;
		res_d.address    = src.address;
		res_d.configured = src.configured;
		res_d.dtr        = src.dtr;
	end

	assign can_load   = !out_valid_q || res_ready;
	assign load_first = (state_q == B_IDLE) && !empty && can_load;
	assign load_next  = (state_q == B_RUN) && can_load;
	assign pop        = load_first;
	assign res_valid  = out_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_first || load_next) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (load_first && (head.dlen != '0) && !is_last) begin
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (load_next && is_last) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_first || load_next) begin
			res_q <= res_d;
		end
		if (load_first) begin
			cur_q  <= head;
			widx_q <= 5'd1;
		end else if (load_next) begin
			widx_q <= widx_q + 5'd1;
		end
	end

	`UCRR_ASSERT_IMPL(a_run_has_beat, clk, arst_n, state_q == B_RUN, out_valid_q,
		"no beat held while streaming")
	`UCRR_ASSERT_IMPL(a_run_no_pop, clk, arst_n, state_q == B_RUN, !pop,
		"queue popped while streaming")
	`UCRR_ASSERT_IMPL(a_status_is_last, clk, arst_n, out_valid_q && !res_q.word_valid,
		res_q.last, "status beat not marked last")

endmodule

`default_nettype wire

// ----- sim/usb_control_request_responder_tb.sv -----
// ----------------------------------------------------------------------------
// USB control request responder: testbench
// Streams setup and OUT data beats into the endpoint 0 responder, predicts
// every status and descriptor beat from a model of the request handling and
// checks the returned beats field by field, in order. Both sides idle at
// random, the receiver once holds off long enough to stall the input, and
// the identifier registers are rewritten between phases.
// ----------------------------------------------------------------------------

module usb_control_request_responder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ucrr_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD    = 400;

	localparam logic [7:0] RT_HOST_TO_DEV = 8'h00;
	localparam logic [7:0] RT_CLASS_OUT   = 8'h21;
	localparam logic [7:0] RT_DEV_TO_HOST = 8'h80;

	localparam logic [7:0] REQ_SET_LINE_CODING = 8'd32;
	localparam logic [7:0] REQ_VENDOR_ANY      = 8'hFF;

	localparam logic [15:0] DESC_STRING = 16'h0300;

	localparam logic [7:0] CONFIG_BYTES [0:66] = '{
		8'd9, 8'd2, 8'd67, 8'd0, 8'd2, 8'd1, 8'd0, 8'd192, 8'd50,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'd2, 8'd2, 8'd0, 8'd0,
		8'd5, 8'd36, 8'd0, 8'd16, 8'd1,
		8'd5, 8'd36, 8'd1, 8'd0, 8'd1,
		8'd4, 8'd36, 8'd2, 8'd2,
		8'd5, 8'd36, 8'd6, 8'd0, 8'd1,
		8'd7, 8'd5, 8'd130, 8'd3, 8'd8, 8'd0, 8'd255,
		8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'd10, 8'd0, 8'd0, 8'd0,
		8'd7, 8'd5, 8'd1, 8'd2, 8'd64, 8'd0, 8'd0,
		8'd7, 8'd5, 8'd129, 8'd2, 8'd64, 8'd0, 8'd0
	};

	typedef struct {
		logic        kind;
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] length;
		logic [10:0] count;
	} ep0_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ep0_request_t pending_requests [$];
	result_t      expected_beats [$];
	ep0_request_t request_on_bus;

	logic [15:0] vid_setting = VENDOR_ID_RESET;
	logic [15:0] pid_setting = PRODUCT_ID_RESET;
	logic [15:0] host_len_left = '0;
	logic [6:0]  dev_addr = '0;
	logic        dev_configured = 1'b0;
	logic        dtr_state = 1'b0;

	logic idling_on = 1'b1;
	logic hold_start = 1'b0;
	int   hold_left = 0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   error_count = 0;
	int   cycle_count = 0;

	usb_control_request_responder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void queue_status_beat(input logic armed);
		result_t beat;
		beat.armed = armed;
		beat.len = '0;
		beat.word_valid = 1'b0;
		beat.word = '0;
		beat.last = 1'b1;
		beat.address = dev_addr;
		beat.configured = dev_configured;
		beat.dtr = dtr_state;
		expected_beats.push_back(beat);
	endfunction

	function automatic void predict_ep0_response(input ep0_request_t req);
		logic [7:0]  dev_bytes [0:17];
		logic [7:0]  b;
		logic [31:0] word;
		desc_sel_t   sel;
		result_t     beat;
		int          span;
		int          nwords;
		int          pos;
		sel = SEL_NONE;
		span = 0;
		if (req.kind == KIND_OUT) begin
			if (req.count >= host_len_left) begin
				host_len_left = '0;
			end else begin
				host_len_left = host_len_left - req.count;
			end
			queue_status_beat(host_len_left == '0);
			return;
		end
		host_len_left = req.length;
		case (req.code)
			REQ_SET_ADDRESS: begin
				dev_addr = req.value[6:0];
			end
			REQ_GET_DESCRIPTOR: begin
				if (req.value == DESC_DEVICE) begin
					sel = SEL_DEVICE;
					span = 18;
				end else if (req.value == DESC_CONFIG) begin
					sel = SEL_CONFIG;
					span = 67;
				end
			end
			REQ_SET_CONFIGURATION: begin
				dev_configured = 1'b1;
			end
			REQ_SET_CONTROL_LINE_STATE: begin
				dtr_state = req.value[0];
			end
			default: begin
			end
		endcase
		if (!(req.length == '0 || req.rtype[7])) begin
			queue_status_beat(1'b0);
			return;
		end
		if (span > req.length) begin
			span = req.length;
		end
		if (span == 0) begin
			queue_status_beat(1'b1);
			return;
		end
		dev_bytes = '{8'd18, 8'd1, 8'd0, 8'd2, 8'd2, 8'd0, 8'd0, 8'd64,
			vid_setting[7:0], vid_setting[15:8], pid_setting[7:0], pid_setting[15:8],
			8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd1};
		nwords = (span + 3) / 4;
		for (int w = 0; w < nwords; w++) begin
			word = '0;
			for (int k = 0; k < 4; k++) begin
				pos = w * 4 + k;
				b = '0;
				if (pos < span) begin
					b = (sel == SEL_DEVICE) ? dev_bytes[pos] : CONFIG_BYTES[pos];
				end
				word[8 * k +: 8] = b;
			end
			beat.armed = 1'b1;
			beat.len = span[6:0];
			beat.word_valid = 1'b1;
			beat.word = word;
			beat.last = (w == nwords - 1);
			beat.address = dev_addr;
			beat.configured = dev_configured;
			beat.dtr = dtr_state;
			expected_beats.push_back(beat);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ep0_request_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_ep0_response(request_on_bus);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					request_on_bus <= next_req;
					s_tdata <= {5'd0, next_req.count, next_req.length, next_req.value,
						next_req.code, next_req.rtype};
					s_tuser <= next_req.kind;
					s_tvalid <= 1'b1;
					if (idling_on && $urandom_range(0, 3) == 0) begin
						send_gap <= $urandom_range(1, 11);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_start) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		logic    ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.armed = m_tuser[0];
				seen.len = m_tdata[6:0];
				seen.word_valid = m_tuser[1];
				seen.word = m_tdata[38:7];
				seen.last = m_tlast;
				seen.address = m_tdata[45:39];
				seen.configured = m_tdata[46];
				seen.dtr = m_tdata[47];
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat: expected none, got 0x%0h", $time, seen);
					error_count++;
				end else begin
					want = expected_beats.pop_front();
					compare_field("reply_armed", want.armed, seen.armed);
					compare_field("reply_length", want.len, seen.len);
					compare_field("word_valid", want.word_valid, seen.word_valid);
					compare_field("reply_word", want.word, seen.word);
					compare_field("last", want.last, seen.last);
					compare_field("device_address", want.address, seen.address);
					compare_field("configured", want.configured, seen.configured);
					compare_field("line_dtr", want.dtr, seen.dtr);
				end
			end
			ready_next = 1'b1;
			if (hold_start || hold_left != 0) begin
				ready_next = 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				ready_next = 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 10);
				ready_next = 1'b0;
			end
			m_tready <= ready_next;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_request(input logic kind, input logic [7:0] rtype,
			input logic [7:0] code, input logic [15:0] value, input logic [15:0] length,
			input logic [10:0] count);
		ep0_request_t req;
		req.kind = kind;
		req.rtype = rtype;
		req.code = code;
		req.value = value;
		req.length = length;
		req.count = count;
		pending_requests.push_back(req);
	endtask

	task automatic write_register(input logic index, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_VENDOR_ID) begin
			vid_setting = value;
		end else begin
			pid_setting = value;
		end
	endtask

	task automatic wait_until_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random_requests(input int count);
		int          n;
		int          pick;
		int          parts;
		int          left;
		int          chunk;
		logic [15:0] value;
		logic [15:0] length;
		logic [7:0]  rtype;
		logic [7:0]  code;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				pick = $urandom_range(0, 9);
				value = (pick < 4) ? DESC_DEVICE : (pick < 8) ? DESC_CONFIG :
					(pick == 8) ? (DESC_STRING | $urandom_range(0, 3)) : $urandom;
				pick = $urandom_range(0, 9);
				length = (pick == 0) ? 16'd0 : (pick < 7) ? $urandom_range(1, 80) :
					(pick == 7) ? 16'd255 : $urandom;
				pick = $urandom_range(0, 9);
				rtype = (pick < 7) ? RT_DEV_TO_HOST : (pick < 9) ? (8'h80 | $urandom) :
					(8'h7F & $urandom);
				push_request(KIND_SETUP, rtype, REQ_GET_DESCRIPTOR, value, length, $urandom);
				n++;
			end else if (pick < 55) begin
				pick = $urandom_range(0, 2);
				code = (pick == 0) ? REQ_SET_ADDRESS : (pick == 1) ? REQ_SET_CONFIGURATION :
					REQ_SET_CONTROL_LINE_STATE;
				rtype = (code == REQ_SET_CONTROL_LINE_STATE) ? RT_CLASS_OUT : RT_HOST_TO_DEV;
				length = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 16'd0;
				push_request(KIND_SETUP, rtype, code, $urandom, length, $urandom);
				n++;
			end else if (pick < 85) begin
				left = $urandom_range(1, 300);
				code = ($urandom_range(0, 3) == 0) ? REQ_SET_CONTROL_LINE_STATE :
					REQ_SET_LINE_CODING;
				push_request(KIND_SETUP, RT_CLASS_OUT, code, $urandom, left, $urandom);
				parts = $urandom_range(1, 3);
				for (int p = 0; p < parts; p++) begin
					if (p == parts - 1) begin
						chunk = left;
						if ($urandom_range(0, 3) == 0) begin
							chunk = chunk + $urandom_range(0, 100);
						end
					end else begin
						chunk = $urandom_range(0, left);
					end
					left = left - chunk;
					push_request(KIND_OUT, $urandom, $urandom, $urandom, $urandom, chunk);
				end
				n += parts + 1;
			end else begin
				push_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				n++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd64,
			11'h7FF);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd18, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_CONFIG, 16'hFFFF, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_CONFIG, 16'd9, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_CONFIG, 16'd1, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd0, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_STRING, 16'd255, 0);
		push_request(KIND_SETUP, RT_HOST_TO_DEV, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd18, 0);
		push_request(KIND_OUT, 0, 0, 0, 0, 11'd5);
		push_request(KIND_OUT, 0, 0, 0, 0, 11'd13);
		push_request(KIND_OUT, 0, 0, 0, 0, 11'd0);
		push_request(KIND_SETUP, RT_HOST_TO_DEV, REQ_SET_ADDRESS, 16'hFFFF, 16'd0, 0);
		push_request(KIND_SETUP, RT_HOST_TO_DEV, REQ_SET_ADDRESS, 16'h0000, 16'd0, 0);
		push_request(KIND_SETUP, RT_HOST_TO_DEV, REQ_SET_CONFIGURATION, 16'd1, 16'd0, 0);
		push_request(KIND_SETUP, RT_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'd3, 16'd0, 0);
		push_request(KIND_SETUP, RT_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'hFFFE, 16'd0, 0);
		push_request(KIND_SETUP, 8'hFF, REQ_VENDOR_ANY, 16'hFFFF, 16'hFFFF, 0);
		push_request(KIND_SETUP, RT_CLASS_OUT, REQ_SET_LINE_CODING, 16'd0, 16'd7, 0);
		push_request(KIND_OUT, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
		push_request(KIND_SETUP, RT_CLASS_OUT, REQ_SET_CONTROL_LINE_STATE, 16'd1, 16'hFFFF,
			0);
		push_request(KIND_OUT, 0, 0, 0, 0, 11'h7FF);
		push_request(KIND_SETUP, RT_HOST_TO_DEV, REQ_SET_ADDRESS, 16'h0055, 16'd0, 0);
		push_request(KIND_SETUP, RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd17, 0);
		wait_until_drained();

		write_register(REG_VENDOR_ID, 16'h0000);
		write_register(REG_PRODUCT_ID, 16'h0000);
		queue_random_requests(90);
		wait_until_drained();

		write_register(REG_VENDOR_ID, 16'hFFFF);
		write_register(REG_PRODUCT_ID, 16'hFFFF);
		queue_random_requests(90);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		wait_until_drained();

		write_register(REG_PRODUCT_ID, $urandom);
		write_register(REG_VENDOR_ID, $urandom);
		queue_random_requests(90);
		wait_until_drained();

		idling_on <= 1'b0;
		write_register(REG_VENDOR_ID, $urandom);
		write_register(REG_PRODUCT_ID, $urandom);
		queue_random_requests(90);
		wait_until_drained();

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/ucrr_pkg.sv
design/ucrr_front.sv
design/ucrr_queue.sv
design/ucrr_back.sv
design/usb_control_request_responder.sv
sim/usb_control_request_responder_tb.sv
